// ===== src/lss_pkg.sv =====
`default_nettype none

package lss_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LONG_PRESS_MS   = 3'd0,
        REG_DEBOUNCE_MS     = 3'd1,
        REG_LOW_BATTERY_DV  = 3'd2,
        REG_OVER_POWER_MW   = 3'd3,
        REG_OVER_POWER_LIM  = 3'd4,
        REG_SAMPLE_PERIOD   = 3'd5
    } lss_reg_idx_t;

    // Register reset values
    localparam logic [15:0] RST_LONG_PRESS_MS  = 16'd2000;
    localparam logic [9:0]  RST_DEBOUNCE_MS    = 10'd30;
    localparam logic [15:0] RST_LOW_BATTERY_DV = 16'd75;
    localparam logic [15:0] RST_OVER_POWER_MW  = 16'd30000;
    localparam logic [7:0]  RST_OVER_POWER_LIM = 8'd10;
    localparam logic [7:0]  RST_SAMPLE_PERIOD  = 8'd20;

    // Radio frame codes
    localparam logic [7:0] CMD_HEADER = 8'hAA;
    localparam logic [7:0] CMD_OFF    = 8'h00;
    localparam logic [7:0] CMD_ON     = 8'h01;

    // Beep lengths in ms
    localparam logic [31:0] SHORT_BEEP_MS = 32'd50;
    localparam logic [31:0] ACK_BEEP_MS   = 32'd100;
    localparam logic [31:0] WARN_BEEP_MS  = 32'd500;

    localparam logic [7:0] OVER_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [9:0]  debounce_ms;
        logic [15:0] low_battery_decivolts;
        logic [15:0] over_power_mw;
        logic [7:0]  over_power_limit;
        logic [7:0]  sample_period_ticks;
    } lss_cfg_t;

    // Declared MSB first, so now_ms sits in the lowest bits.
    typedef struct packed {
        logic [15:0] power_mw;
        logic [7:0]  frame_command;
        logic [15:0] frame_voltage;
        logic [7:0]  frame_header;
        logic        frame_valid;
        logic        button_pressed;
        logic [31:0] now_ms;
    } lss_item_t;

    // Declared MSB first, so switch_on sits in bit 0.
    typedef struct packed {
        logic [15:0] battery_decivolts;
        logic        reply_switch_on;
        logic [15:0] reply_power_mw;
        logic        reply_valid;
        logic        low_battery;
        logic        locked_off;
        logic        buzzer_on;
        logic        switch_on;
    } lss_result_t;

    localparam int ITEM_W   = $bits(lss_item_t);
    localparam int RESULT_W = $bits(lss_result_t);
    localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/load_switch_supervisor_top.sv =====
// Load switch supervisor: one request per poll tick in, one result per tick out.
//
// Input stream (s_*): each request carries the tick timestamp, button level,
// an optional radio frame and the current power reading. Result stream (m_*):
// switch, buzzer, lock and alarm drives, plus the reply payload for a frame.
// Configuration (cfg_*): single-cycle register writes, no read-back; write
// only while no request is in flight.
//
// Path: an accepted request is held in the input register, then its result is
// captured in the result register and shown on m_* (two register stages).
// Throughput: one request per cycle sustained while m_tready is high; the
// whole tick update is one combinational pass between the input and result registers.
//
// Backpressure: while m_tready is low the result register holds; the input
// register keeps one more request, then s_tready drops. Nothing is lost.
// Reset (aresetn low, synchronous): all supervisor state and the
// configuration registers return to their defaults, both streams go empty.
`default_nettype none

module load_switch_supervisor_top #(
    parameter int ALARM_PERIOD = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // tdata: now_ms[31:0], button_pressed[32], frame_valid[33],
    //        frame_header[41:34], frame_voltage[57:42], frame_command[65:58],
    //        power_mw[81:66], zero fill[87:82]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lss_pkg::S_DATA_W-1:0]      s_tdata,

    // tdata: switch_on[0], buzzer_on[1], locked_off[2], low_battery[3],
    //        reply_valid[4], reply_power_mw[20:5], reply_switch_on[21],
    //        battery_decivolts[37:22], zero fill[39:38]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lss_pkg::M_DATA_W-1:0]           m_tdata,

    input  wire logic                              cfg_wr_en,
    input  wire logic [lss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [lss_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import lss_pkg::*;

    lss_cfg_t    cfg_reg;
    logic        in_valid_reg;
    lss_item_t   item_reg;
    logic        out_valid_reg;
    lss_result_t res_reg;
    lss_result_t res_next;
    logic        advance;

    // step the core when a request is held and the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - RESULT_W)'(0), res_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms         <= RST_LONG_PRESS_MS;
            cfg_reg.debounce_ms           <= RST_DEBOUNCE_MS;
            cfg_reg.low_battery_decivolts <= RST_LOW_BATTERY_DV;
            cfg_reg.over_power_mw         <= RST_OVER_POWER_MW;
            cfg_reg.over_power_limit      <= RST_OVER_POWER_LIM;
            cfg_reg.sample_period_ticks   <= RST_SAMPLE_PERIOD;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LONG_PRESS_MS:  cfg_reg.long_press_ms         <= cfg_wr_data;
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms           <= cfg_wr_data[9:0];
                REG_LOW_BATTERY_DV: cfg_reg.low_battery_decivolts <= cfg_wr_data;
                REG_OVER_POWER_MW:  cfg_reg.over_power_mw         <= cfg_wr_data;
                REG_OVER_POWER_LIM: cfg_reg.over_power_limit      <= cfg_wr_data[7:0];
                REG_SAMPLE_PERIOD:  cfg_reg.sample_period_ticks   <= cfg_wr_data[7:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_tdata[ITEM_W-1:0];
        end
    end

    lss_core #(
        .ALARM_PERIOD (ALARM_PERIOD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lss_core.sv =====
`default_nettype none

module lss_core #(
    parameter int ALARM_PERIOD = 12
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire lss_pkg::lss_item_t  item,
    input  wire lss_pkg::lss_cfg_t   cfg,
    output lss_pkg::lss_result_t     result
);
    import lss_pkg::*;

    localparam int APW = $clog2(ALARM_PERIOD);
    localparam logic [APW:0]   AP_WRAP  = (APW+1)'(ALARM_PERIOD);
    localparam logic [APW-1:0] AP_ZERO  = APW'(0);
    localparam logic [APW-1:0] AP_TWO   = APW'(2);
    localparam logic [APW-1:0] AP_FOUR  = APW'(4);
    localparam logic [APW-1:0] AP_NINE  = APW'(9);

    typedef enum logic [1:0] {
        BTN_IDLE = 2'd0,
        BTN_HELD = 2'd1,
        BTN_LONG = 2'd2
    } btn_phase_t;

    btn_phase_t      btn_reg, btn_next;
    logic [31:0]     press_reg, press_next;
    logic            sw_reg, sw_next;
    logic            lock_reg, lock_next;
    logic [15:0]     bat_reg, bat_next;
    logic            alarm_reg, alarm_next;
    logic [APW-1:0]  aphase_reg, aphase_next;
    logic            busy_reg, busy_next;
    logic [1:0]      step_reg, step_next;
    logic [31:0]     dline_reg, dline_next;
    logic            buzz_reg, buzz_next;
    logic [7:0]      scount_reg, scount_next;
    logic [15:0]     plevel_reg, plevel_next;
    logic [7:0]      ocount_reg, ocount_next;

    logic [31:0]     press_len;
    logic [31:0]     dline_diff;
    logic [8:0]      scount_inc;
    logic [APW:0]    aphase_inc;

    always_comb begin
        btn_next    = btn_reg;
        press_next  = press_reg;
        sw_next     = sw_reg;
        lock_next   = lock_reg;
        bat_next    = bat_reg;
        alarm_next  = alarm_reg;
        aphase_next = aphase_reg;
        busy_next   = busy_reg;
        step_next   = step_reg;
        dline_next  = dline_reg;
        buzz_next   = buzz_reg;
        scount_next = scount_reg;
        plevel_next = plevel_reg;
        ocount_next = ocount_reg;
        result      = '0;

        press_len   = item.now_ms - press_reg;

        // button
        if (item.button_pressed) begin
            if (btn_reg == BTN_IDLE) begin
                btn_next   = BTN_HELD;
                press_next = item.now_ms;
            end else if (btn_reg == BTN_HELD && press_len >= {16'd0, cfg.long_press_ms}) begin
                btn_next = BTN_LONG;
                if (!busy_next) begin
                    buzz_next  = 1'b1;
                    dline_next = item.now_ms + SHORT_BEEP_MS;
                    busy_next  = 1'b1;
                    step_next  = 2'd0;
                end
            end
        end else if (btn_reg == BTN_HELD || btn_reg == BTN_LONG) begin
            btn_next = BTN_IDLE;
            if (press_len > {22'd0, cfg.debounce_ms}) begin
                if (press_len < {16'd0, cfg.long_press_ms}) begin
                    // short press: off, lock, two-beep pattern
                    sw_next    = 1'b0;
                    lock_next  = 1'b1;
                    step_next  = 2'd1;
                    dline_next = item.now_ms + SHORT_BEEP_MS;
                    busy_next  = 1'b1;
                    buzz_next  = 1'b1;
                end else begin
                    sw_next   = 1'b1;
                    lock_next = 1'b0;
                    if (!busy_next) begin
                        buzz_next  = 1'b1;
                        dline_next = item.now_ms + ACK_BEEP_MS;
                        busy_next  = 1'b1;
                        step_next  = 2'd0;
                    end
                end
            end
        end

        // radio frame
        if (item.frame_valid) begin
            result.reply_valid     = 1'b1;
            result.reply_power_mw  = plevel_reg;
            result.reply_switch_on = sw_next;
            if (item.frame_header == CMD_HEADER) begin
                bat_next   = item.frame_voltage;
                alarm_next = (item.frame_voltage != 16'd0) &&
                             (item.frame_voltage < cfg.low_battery_decivolts);
                if (item.frame_command == CMD_OFF) begin
                    if (sw_next) begin
                        sw_next    = 1'b0;
                        step_next  = 2'd1;
                        dline_next = item.now_ms + SHORT_BEEP_MS;
                        busy_next  = 1'b1;
                        buzz_next  = 1'b1;
                    end
                end else if (item.frame_command == CMD_ON) begin
                    if (!lock_next && !sw_next) begin
                        sw_next = 1'b1;
                        if (!busy_next) begin
                            buzz_next  = 1'b1;
                            dline_next = item.now_ms + ACK_BEEP_MS;
                            busy_next  = 1'b1;
                            step_next  = 2'd0;
                        end
                    end
                end
            end
        end

        // low-battery pattern
        aphase_inc = {1'b0, aphase_reg} + (APW+1)'(1);
        if (alarm_next) begin
            aphase_next = (aphase_inc >= AP_WRAP) ? AP_ZERO : aphase_inc[APW-1:0];
            if (!busy_next) begin
                buzz_next = (aphase_next == AP_ZERO) || (aphase_next == AP_TWO) ||
                            (aphase_next >= AP_FOUR && aphase_next < AP_NINE);
            end
        end else begin
            if (!busy_next) begin
                buzz_next = 1'b0;
            end
            aphase_next = AP_ZERO;
        end

        // power sampling
        scount_inc  = {1'b0, scount_reg} + 9'd1;
        scount_next = scount_inc[7:0];
        if (scount_inc >= {1'b0, cfg.sample_period_ticks}) begin
            scount_next = 8'd0;
            plevel_next = item.power_mw;
            if (item.power_mw > cfg.over_power_mw) begin
                if (!busy_next) begin
                    buzz_next  = 1'b1;
                    dline_next = item.now_ms + WARN_BEEP_MS;
                    busy_next  = 1'b1;
                    step_next  = 2'd0;
                end
                if (ocount_next < OVER_COUNT_MAX) begin
                    ocount_next = ocount_next + 8'd1;
                end
                if (ocount_next > cfg.over_power_limit) begin
                    sw_next     = 1'b0;
                    ocount_next = 8'd0;
                end
            end else begin
                ocount_next = 8'd0;
            end
        end

        // beep sequencer, wrap-safe deadline
        dline_diff = item.now_ms - dline_next;
        if (busy_next && !dline_diff[31]) begin
            if (step_next == 2'd1) begin
                buzz_next  = 1'b0;
                step_next  = 2'd2;
                dline_next = item.now_ms + SHORT_BEEP_MS;
            end else if (step_next == 2'd2) begin
                buzz_next  = 1'b1;
                step_next  = 2'd3;
                dline_next = item.now_ms + SHORT_BEEP_MS;
            end else begin
                buzz_next = 1'b0;
                busy_next = 1'b0;
                step_next = 2'd0;
            end
        end

        result.switch_on         = sw_next;
        result.buzzer_on         = buzz_next;
        result.locked_off        = lock_next;
        result.low_battery       = alarm_next;
        result.battery_decivolts = bat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btn_reg    <= BTN_IDLE;
            press_reg  <= '0;
            sw_reg     <= 1'b0;
            lock_reg   <= 1'b0;
            bat_reg    <= '0;
            alarm_reg  <= 1'b0;
            aphase_reg <= '0;
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            dline_reg  <= '0;
            buzz_reg   <= 1'b0;
            scount_reg <= '0;
            plevel_reg <= '0;
            ocount_reg <= '0;
        end else if (advance) begin
            btn_reg    <= btn_next;
            press_reg  <= press_next;
            sw_reg     <= sw_next;
            lock_reg   <= lock_next;
            bat_reg    <= bat_next;
            alarm_reg  <= alarm_next;
            aphase_reg <= aphase_next;
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            dline_reg  <= dline_next;
            buzz_reg   <= buzz_next;
            scount_reg <= scount_next;
            plevel_reg <= plevel_next;
            ocount_reg <= ocount_next;
        end
    end

`ifndef SYNTH
    // the manual lock is only ever set together with switching off
    a_lock_implies_off: assert property (@(posedge aclk) disable iff (!aresetn)
        lock_reg |-> !sw_reg)
        else $error("lock set while switch on");

    a_step_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 2'd0) |-> busy_reg)
        else $error("beep step without busy sequencer");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, aphase_reg} < AP_WRAP)
        else $error("alarm phase out of range");

    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !alarm_reg |-> (aphase_reg == AP_ZERO))
        else $error("alarm phase running with alarm off");
`endif

endmodule

`default_nettype wire

// ===== test/load_switch_supervisor_top_test.sv =====
`timescale 1ns / 100ps

module load_switch_supervisor_top_test;
    import lss_pkg::*;

    localparam int ALARM_PERIOD = 12;

    // Config indexes the block has no register for; writes there must do nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [CFG_ADDR_W-1:0] REG_ORDER [8] = '{
        REG_LONG_PRESS_MS, REG_DEBOUNCE_MS, REG_LOW_BATTERY_DV, REG_OVER_POWER_MW,
        REG_OVER_POWER_LIM, REG_SAMPLE_PERIOD, REG_SPARE_LO, REG_SPARE_HI
    };

    // Tracks supervisor state per accepted request and holds the drive outputs
    // each request should produce, oldest first.
    class switch_tracker;
        logic [15:0] long_press, low_batt, over_mw;
        logic [9:0]  debounce;
        logic [7:0]  over_lim, period;

        logic [1:0]  btn_phase;
        logic [31:0] press_t0;
        logic        sw, lock, alarm, busy, buzz;
        logic [15:0] batt, last_pwr;
        logic [3:0]  alarm_pos;
        logic [1:0]  step;
        logic [31:0] deadline;
        logic [7:0]  tick_cnt, over_run;

        lss_result_t drive_queue[$];
        int          faults;

        function new();
            long_press = RST_LONG_PRESS_MS;
            debounce   = RST_DEBOUNCE_MS;
            low_batt   = RST_LOW_BATTERY_DV;
            over_mw    = RST_OVER_POWER_MW;
            over_lim   = RST_OVER_POWER_LIM;
            period     = RST_SAMPLE_PERIOD;
            btn_phase  = '0;
            press_t0   = '0;
            sw         = 1'b0;
            lock       = 1'b0;
            alarm      = 1'b0;
            busy       = 1'b0;
            buzz       = 1'b0;
            batt       = '0;
            last_pwr   = '0;
            alarm_pos  = '0;
            step       = '0;
            deadline   = '0;
            tick_cnt   = '0;
            over_run   = '0;
            faults     = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_LONG_PRESS_MS:  long_press = val;
                REG_DEBOUNCE_MS:    debounce   = val[9:0];
                REG_LOW_BATTERY_DV: low_batt   = val;
                REG_OVER_POWER_MW:  over_mw    = val;
                REG_OVER_POWER_LIM: over_lim   = val[7:0];
                REG_SAMPLE_PERIOD:  period     = val[7:0];
                default: ;
            endcase
        endfunction

        function void start_beep(logic [31:0] now, logic [31:0] dur);
            buzz     = 1'b1;
            deadline = now + dur;
            busy     = 1'b1;
            step     = 2'd0;
        endfunction

        function void stop_beep();
            buzz = 1'b0;
            busy = 1'b0;
            step = 2'd0;
        endfunction

        // two short beeps; only starts when nothing else is sounding
        function void shutdown_beeps(logic [31:0] now);
            if (!busy) begin
                step     = 2'd1;
                deadline = now + SHORT_BEEP_MS;
                busy     = 1'b1;
                buzz     = 1'b1;
            end
        endfunction

        function void take_tick(lss_item_t it);
            lss_result_t r;
            logic [31:0] dur;
            logic [31:0] late;
            logic [8:0]  cnt_next;
            r = '0;

            if (btn_phase > 2'd2)
                btn_phase = 2'd0;

            // button
            dur = it.now_ms - press_t0;
            if (it.button_pressed) begin
                if (btn_phase == 2'd0) begin
                    btn_phase = 2'd1;
                    press_t0  = it.now_ms;
                end else if (btn_phase == 2'd1 && dur >= {16'd0, long_press}) begin
                    btn_phase = 2'd2;
                    if (!busy)
                        start_beep(it.now_ms, SHORT_BEEP_MS);
                end
            end else if (btn_phase != 2'd0) begin
                btn_phase = 2'd0;
                if (dur > {22'd0, debounce}) begin
                    if (dur < {16'd0, long_press}) begin
                        sw   = 1'b0;
                        lock = 1'b1;
                        if (busy)
                            stop_beep();
                        shutdown_beeps(it.now_ms);
                    end else begin
                        sw   = 1'b1;
                        lock = 1'b0;
                        if (!busy)
                            start_beep(it.now_ms, ACK_BEEP_MS);
                    end
                end
            end

            // radio frame
            if (it.frame_valid) begin
                r.reply_valid    = 1'b1;
                r.reply_power_mw = last_pwr;
                r.reply_switch_on = sw;
                if (it.frame_header == CMD_HEADER) begin
                    batt  = it.frame_voltage;
                    alarm = (it.frame_voltage != 16'd0) && (it.frame_voltage < low_batt);
                    if (it.frame_command == CMD_OFF) begin
                        if (sw) begin
                            sw = 1'b0;
                            if (busy)
                                stop_beep();
                            shutdown_beeps(it.now_ms);
                        end
                    end else if (it.frame_command == CMD_ON) begin
                        if (!lock && !sw) begin
                            sw = 1'b1;
                            if (!busy)
                                start_beep(it.now_ms, ACK_BEEP_MS);
                        end
                    end
                end
            end

            // low-battery pattern: on at 0, 2 and 4..8 of each period
            if (alarm) begin
                alarm_pos = 4'((int'(alarm_pos) + 1) % ALARM_PERIOD);
                if (!busy)
                    buzz = (alarm_pos == 4'd0) || (alarm_pos == 4'd2) ||
                           (alarm_pos >= 4'd4 && alarm_pos < 4'd9);
            end else begin
                if (!busy)
                    buzz = 1'b0;
                alarm_pos = 4'd0;
            end

            // power sampling, over-power run counter saturates
            cnt_next = {1'b0, tick_cnt} + 9'd1;
            if (cnt_next >= {1'b0, period}) begin
                tick_cnt = 8'd0;
                last_pwr = it.power_mw;
                if (it.power_mw > over_mw) begin
                    if (!busy)
                        start_beep(it.now_ms, WARN_BEEP_MS);
                    if (over_run < OVER_COUNT_MAX)
                        over_run = over_run + 8'd1;
                    if (over_run > over_lim) begin
                        sw       = 1'b0;
                        over_run = 8'd0;
                    end
                end else begin
                    over_run = 8'd0;
                end
            end else begin
                tick_cnt = cnt_next[7:0];
            end

            // beep sequencer, deadline reached when the wrapped difference is not negative
            late = it.now_ms - deadline;
            if (busy && !late[31]) begin
                if (step == 2'd1) begin
                    buzz     = 1'b0;
                    step     = 2'd2;
                    deadline = it.now_ms + SHORT_BEEP_MS;
                end else if (step == 2'd2) begin
                    buzz     = 1'b1;
                    step     = 2'd3;
                    deadline = it.now_ms + SHORT_BEEP_MS;
                end else begin
                    stop_beep();
                end
            end

            r.switch_on         = sw;
            r.buzzer_on         = buzz;
            r.locked_off        = lock;
            r.low_battery       = alarm;
            r.battery_decivolts = batt;
            drive_queue.push_back(r);
        endfunction

        function void check_drive(logic [M_DATA_W-1:0] data);
            lss_result_t got;
            lss_result_t want;
            got = lss_result_t'(data[RESULT_W-1:0]);
            if (drive_queue.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result %h with nothing pending", got);
            end else begin
                want = drive_queue.pop_front();
                if (got.switch_on !== want.switch_on || got.buzzer_on !== want.buzzer_on ||
                    got.locked_off !== want.locked_off ||
                    got.low_battery !== want.low_battery ||
                    got.reply_valid !== want.reply_valid ||
                    got.reply_power_mw !== want.reply_power_mw ||
                    got.reply_switch_on !== want.reply_switch_on ||
                    got.battery_decivolts !== want.battery_decivolts) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("mismatch: expected sw=%b bz=%b lk=%b lb=%b rv=%b rp=%0d rs=%b bv=%0d",
                                 want.switch_on, want.buzzer_on, want.locked_off,
                                 want.low_battery, want.reply_valid, want.reply_power_mw,
                                 want.reply_switch_on, want.battery_decivolts);
                        $display("          actual   sw=%b bz=%b lk=%b lb=%b rv=%b rp=%0d rs=%b bv=%0d",
                                 got.switch_on, got.buzzer_on, got.locked_off,
                                 got.low_battery, got.reply_valid, got.reply_power_mw,
                                 got.reply_switch_on, got.battery_decivolts);
                    end
                end
            end
        endfunction
    endclass

    // One run of random ticks under one register setting.
    typedef struct {
        logic [15:0] long_press, debounce, low_batt, over_mw, over_lim, period;
        int          ticks;
        int          hot_len;   // mean length of an over-power stretch, in ticks
    } phase_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    switch_tracker tracker = new();

    // stimulus state shared by the generator
    logic [31:0] clock_ms  = 32'd0;
    int          press_left = 0;
    logic        hot        = 1'b0;
    int          hot_len    = 30;
    logic        quiet      = 1'b0;   // no idling on either side
    int          hold_req   = 0;      // cycles the result side is to hold off

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    load_switch_supervisor_top #(
        .ALARM_PERIOD(ALARM_PERIOD)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic lss_item_t make_tick(logic [31:0] now, logic btn, logic fv,
                                            logic [7:0] hdr, logic [15:0] volts,
                                            logic [7:0] cmd, logic [15:0] pwr);
        lss_item_t it;
        it.now_ms         = now;
        it.button_pressed = btn;
        it.frame_valid    = fv;
        it.frame_header   = hdr;
        it.frame_voltage  = volts;
        it.frame_command  = cmd;
        it.power_mw       = pwr;
        return it;
    endfunction

    // Mostly a well-behaved 50 ms poll with real presses, command frames and
    // over-power stretches; now and then time jumps and button glitches.
    function automatic lss_item_t random_tick();
        lss_item_t it;
        int        r;

        r = $urandom_range(999);
        if (r < 8)
            clock_ms = $urandom();
        else if (r < 40)
            clock_ms += $urandom_range(3000);
        else if (r >= 60)
            clock_ms += 32'd45 + $urandom_range(10);
        it.now_ms = clock_ms;

        // press lengths: glitch, short, long (at 50 ms per tick)
        if (press_left == 0 && $urandom_range(15) == 0) begin
            case ($urandom_range(2))
                0:       press_left = 1 + $urandom_range(1);
                1:       press_left = 2 + $urandom_range(18);
                default: press_left = 25 + $urandom_range(40);
            endcase
        end
        it.button_pressed = (press_left > 0);
        if (press_left > 0)
            press_left--;
        if ($urandom_range(49) == 0)
            it.button_pressed = !it.button_pressed;

        it.frame_valid  = ($urandom_range(5) == 0);
        it.frame_header = ($urandom_range(9) < 8) ? CMD_HEADER : 8'($urandom());
        r = $urandom_range(19);
        it.frame_command = (r < 9) ? CMD_OFF : (r < 18) ? CMD_ON : 8'($urandom());
        r = $urandom_range(9);
        if (r == 0)
            it.frame_voltage = 16'd0;
        else if (r < 5)
            it.frame_voltage = 16'($urandom_range(tracker.low_batt));
        else
            it.frame_voltage = 16'($urandom());

        if (hot)
            hot = ($urandom_range(hot_len - 1) != 0);
        else
            hot = ($urandom_range(19) == 0);
        r = $urandom_range(9);
        if (hot && tracker.over_mw != 16'hFFFF)
            it.power_mw = 16'($urandom_range(65535, tracker.over_mw + 1));
        else if (r == 0)
            it.power_mw = tracker.over_mw;
        else if (r == 1)
            it.power_mw = 16'($urandom());
        else
            it.power_mw = 16'($urandom_range(tracker.over_mw));
        return it;
    endfunction

    // Offer one request, idling first at random; returns at the accepting edge.
    task automatic send_tick(lss_item_t it);
        if (!quiet && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (!quiet && $urandom_range(99) < 32)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(it);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.take_tick(it);
    endtask

    // Stop offering and wait until every pending result is out and the
    // two-stage pipeline is empty, so the block is really idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.drive_queue.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Writes every register, spare indexes included, one per cycle.
    task automatic apply_setting(phase_t ph);
        logic [15:0] vals[8];
        vals = '{ph.long_press, ph.debounce, ph.low_batt, ph.over_mw, ph.over_lim,
                 ph.period, 16'($urandom()), 16'($urandom())};
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= REG_ORDER[i];
            cfg_wr_data <= vals[i];
            @(posedge aclk);
            tracker.set_reg(REG_ORDER[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: checks each accepted result and throttles m_tready.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (aresetn && m_tvalid && m_tready)
                tracker.check_drive(m_tdata);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 32);
            end
            @(posedge aclk);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        phase_t      phases[6];
        logic [31:0] b;
        int          p;
        int          k;

        // reset values, then the extremes of each register, then mixes
        phases[0] = '{16'd2000,  16'd30,   16'd75,    16'd30000, 16'd10,  16'd20,  200, 30};
        phases[1] = '{16'd500,   16'd0,    16'd65535, 16'd0,     16'd0,   16'd1,   150, 30};
        phases[2] = '{16'd65535, 16'd1000, 16'd0,     16'd65535, 16'd255, 16'd255, 150, 30};
        phases[3] = '{16'd1,     16'd0,    16'd120,   16'd20000, 16'd2,   16'd2,   200, 30};
        // zero long-press length; limit 255 so a saturated run never trips
        phases[4] = '{16'd0,     16'd5,    16'd75,    16'd30000, 16'd255, 16'd1,   300, 1000};
        // sample period zero: sample on every tick
        phases[5] = '{16'd800,   16'd60,   16'd200,   16'd1000,  16'd4,   16'd0,   150, 40};

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_LONG_PRESS_MS;
        cfg_wr_data <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset configuration.
        send_tick(make_tick(32'd0, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h00, 16'h0000));
        // all ones; frame with a foreign header only gets a reply
        send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        // release after 17 ms across the wrap: bounce, ignored; remote on
        send_tick(make_tick(32'h0000_0010, 1'b0, 1'b1, CMD_HEADER, 16'd0, CMD_ON, 16'd100));
        // time jumps back: beep deadline not yet reached; low voltage, unknown command
        send_tick(make_tick(32'hFFFF_FF00, 1'b0, 1'b1, CMD_HEADER, 16'd50, 8'h07, 16'd200));
        send_tick(make_tick(32'hFFFF_FF40, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(32'h0000_0080, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        // voltage at threshold is not low; remote off plays the shutdown beeps
        send_tick(make_tick(32'h0000_00D0, 1'b0, 1'b1, CMD_HEADER, 16'd75, CMD_OFF, 16'd0));
        send_tick(make_tick(32'h0000_0100, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(32'h0000_0150, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(32'h0000_01A0, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        // short press: off and locked
        send_tick(make_tick(32'h0000_0200, 1'b1, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(32'h0000_0250, 1'b1, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(32'h0000_02C8, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        // remote on refused while locked
        send_tick(make_tick(32'h0000_0300, 1'b0, 1'b1, CMD_HEADER, 16'd74, CMD_ON, 16'd0));
        // long press: held exactly the long length, then released
        b = 32'h0000_0400;
        send_tick(make_tick(b, 1'b1, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(b + 32'd2000, 1'b1, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(b + 32'd2100, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd0));
        send_tick(make_tick(b + 32'd2150, 1'b0, 1'b1, CMD_HEADER, 16'd80, CMD_OFF, 16'd0));
        send_tick(make_tick(b + 32'd2200, 1'b0, 1'b1, CMD_HEADER, 16'd1, CMD_ON, 16'd30001));
        // 31 ms press: just past the bounce window
        send_tick(make_tick(b + 32'd2250, 1'b1, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd30000));
        send_tick(make_tick(b + 32'd2281, 1'b0, 1'b0, 8'h00, 16'd0, CMD_OFF, 16'd65535));

        // Random part: start near the timestamp wrap.
        clock_ms = 32'hFFFF_C000;
        for (p = 0; p < 6; p++) begin
            drain();
            apply_setting(phases[p]);
            hot_len = phases[p].hot_len;
            hot     = (hot_len > 100);
            for (k = 0; k < phases[p].ticks; k++) begin
                quiet = (p == 3 && k < 150);
                // long result-side hold while requests keep coming: pipeline fills
                if (p == 0 && k == 100)
                    hold_req = 80;
                // sender pause until everything pending has come out
                if (p == 1 && k == 75)
                    drain();
                send_tick(random_tick());
            end
        end
        quiet = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.faults == 0 && tracker.drive_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== load_switch_supervisor_top.f =====
src/lss_pkg.sv
src/lss_core.sv
src/load_switch_supervisor_top.sv
test/load_switch_supervisor_top_test.sv
